/* sv/rht_pkg.sv */
package rht_pkg;

  localparam int unsigned INDEX_BITS_DEF  = 8;
  localparam int unsigned PROBE_SLACK_DEF = 16;
  localparam int unsigned DATA_BITS_DEF   = 32;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned PAY_W   = 32;
  localparam int unsigned LIM_W   = 5;
  localparam int unsigned OCC_W   = 9;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd7;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_FOUND    = 3'd3,
    ST_MISS     = 3'd4
  } status_e;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } rht_in_t;

  typedef struct packed {
    status_e          status;
    logic [PAY_W-1:0] found_payload;
    logic [KEY_W-1:0] dropped_key;
    logic [PAY_W-1:0] dropped_payload;
    logic [OCC_W-1:0] occupancy;
    logic             over_half;
  } rht_out_t;

  typedef struct packed {
    logic    clr;
    logic    load;
    logic    rd;
    logic    step;
    logic    swap;
    logic    put;
    logic    fin;
    status_e code;
    logic    out_load;
  } rht_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic lookup;
    logic at_limit;
    logic guard_hit;
    logic hit;
    logic empty;
    logic farther;
  } rht_sts_t;

endpackage

/* sv/robin_hood_hash_table.sv */
// Channel | Dir | Handshake                 | Beat
// in      | in  | in_valid_i / in_ready_o   | rht_in_t: func, key, payload
// out     | out | out_valid_o / out_ready_i | rht_out_t: status .. over_half
// cfg     | in  | cfg_valid_i / cfg_ready_o | probe cap (5 bits)
//
// One item at a time; each item walks its probe sequence reading one slot per step, and
// the next beat is taken only after its result is loaded into the output register.
// After reset a clearing pass writes every slot (2^INDEX_BITS + PROBE_SLACK slots,
// 272 by default) before the first item is taken; cfg writes are taken always.
// A held result does not block the next item until that item finishes.
module robin_hood_hash_table import rht_pkg::*; #(
  parameter int unsigned INDEX_BITS  = INDEX_BITS_DEF,
  parameter int unsigned PROBE_SLACK = PROBE_SLACK_DEF,
  parameter int unsigned DATA_BITS   = DATA_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rht_in_t          in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rht_out_t         out_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LIM_W-1:0] cfg_data_i
);

  rht_cmd_t cmd;
  rht_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rht_dpath #(
    .INDEX_BITS  (INDEX_BITS),
    .PROBE_SLACK (PROBE_SLACK),
    .DATA_BITS   (DATA_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_o)
  );

endmodule

/* sv/rht_ctrl.sv */
module rht_ctrl import rht_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  rht_sts_t sts_i,
  output rht_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.code = ST_INSERTED;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.at_limit || (!sts_i.lookup && sts_i.guard_hit)) begin
          cmd_o.fin  = 1'b1;
          cmd_o.code = sts_i.lookup ? ST_MISS : ST_OVERFLOW;
          state_d    = S_OUT;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.hit) begin
          cmd_o.fin  = 1'b1;
          cmd_o.code = sts_i.lookup ? ST_FOUND : ST_DUP;
          state_d    = S_OUT;
        end else if (sts_i.lookup) begin
          cmd_o.step = 1'b1;
          state_d    = S_CHECK;
        end else if (sts_i.empty) begin
          cmd_o.put  = 1'b1;
          cmd_o.fin  = 1'b1;
          cmd_o.code = ST_INSERTED;
          state_d    = S_OUT;
        end else if (sts_i.farther) begin
          cmd_o.step = 1'b1;
          state_d    = S_CHECK;
        end else begin
          cmd_o.swap = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* sv/rht_dpath.sv */
module rht_dpath import rht_pkg::*; #(
  parameter int unsigned INDEX_BITS  = INDEX_BITS_DEF,
  parameter int unsigned PROBE_SLACK = PROBE_SLACK_DEF,
  parameter int unsigned DATA_BITS   = DATA_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rht_in_t          in_i,
  input  logic             cfg_valid_i,
  input  logic [LIM_W-1:0] cfg_data_i,
  input  rht_cmd_t         cmd_i,
  output rht_sts_t         sts_o,
  output rht_out_t         out_o
);

  localparam int unsigned HOME_SLOTS  = 1 << INDEX_BITS;
  localparam int unsigned TOTAL_SLOTS = HOME_SLOTS + PROBE_SLACK;
  localparam int unsigned IDX_W       = $clog2(TOTAL_SLOTS);
  localparam int unsigned CNT_W       = $clog2(TOTAL_SLOTS + 1);
  localparam int unsigned GRD_W       = $clog2(TOTAL_SLOTS + 2);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOTAL_SLOTS - 1);
  localparam logic [GRD_W-1:0] GRD_MAX  = GRD_W'(TOTAL_SLOTS);
  localparam logic [CNT_W-1:0] HALF     = CNT_W'(HOME_SLOTS / 2);
  localparam logic [LIM_W-1:0] SLACK    = LIM_W'(PROBE_SLACK);

  typedef struct packed {
    logic                 used;
    logic [LIM_W-1:0]     pdist;
    logic [KEY_W-1:0]     key;
    logic [DATA_BITS-1:0] data;
  } entry_t;

  entry_t mem_q [TOTAL_SLOTS];

  entry_t               rd_q;
  logic [IDX_W-1:0]     addr_q, clr_idx_q, idx;
  logic [KEY_W-1:0]     ck_q;
  logic [DATA_BITS-1:0] cd_q;
  logic [LIM_W:0]       probe_q;
  logic [LIM_W-1:0]     lim_q, lim;
  logic                 lookup_q;
  logic [GRD_W-1:0]     swaps_q;
  logic [CNT_W-1:0]     count_q;
  status_e              status_q;
  rht_out_t             out_q;
  entry_t               wr_entry;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;

  assign lim = (lim_q > SLACK) ? SLACK : lim_q;
  assign idx = IDX_W'(ck_q[INDEX_BITS-1:0]) + IDX_W'(probe_q);

  assign sts_o.clr_last  = (clr_idx_q == LAST_IDX);
  assign sts_o.lookup    = lookup_q;
  assign sts_o.at_limit  = lookup_q ? (probe_q > {1'b0, lim}) : (probe_q >= {1'b0, lim});
  assign sts_o.guard_hit = (swaps_q > GRD_MAX);
  assign sts_o.hit       = rd_q.used && (rd_q.key == ck_q);
  assign sts_o.empty     = !rd_q.used;
  assign sts_o.farther   = ({1'b0, rd_q.pdist} >= probe_q);

  always_comb begin
    wr_en    = cmd_i.clr || cmd_i.put || cmd_i.swap;
    wr_addr  = cmd_i.clr ? clr_idx_q : addr_q;
    wr_entry = cmd_i.clr ? entry_t'('0) : entry_t'{used: 1'b1, pdist: probe_q[LIM_W-1:0],
                                                   key: ck_q, data: cd_q};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_entry;
    if (cmd_i.rd) begin
      rd_q   <= mem_q[idx];
      addr_q <= idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ck_q     <= in_i.key;
      cd_q     <= DATA_BITS'(64'(in_i.payload));
      lookup_q <= (in_i.func == FUNC_LOOKUP);
    end else if (cmd_i.swap) begin
      ck_q <= rd_q.key;
      cd_q <= rd_q.data;
    end
    if (cmd_i.fin) status_q <= cmd_i.code;
    if (cmd_i.out_load) begin
      out_q.status          <= status_q;
      out_q.found_payload   <= (status_q == ST_FOUND) ? PAY_W'(64'(rd_q.data)) : '0;
      out_q.dropped_key     <= (status_q == ST_OVERFLOW) ? ck_q : '0;
      out_q.dropped_payload <= (status_q == ST_OVERFLOW) ? PAY_W'(64'(cd_q)) : '0;
      out_q.occupancy       <= OCC_W'(count_q);
      out_q.over_half       <= (count_q > HALF);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
      count_q   <= '0;
      lim_q     <= LIMIT_RESET;
      probe_q   <= '0;
      swaps_q   <= '0;
    end else begin
      if (cmd_i.clr && clr_idx_q != LAST_IDX) clr_idx_q <= clr_idx_q + 1'b1;
      if (cfg_valid_i) lim_q <= cfg_data_i;
      if (cmd_i.put) count_q <= count_q + 1'b1;
      if (cmd_i.load) begin
        probe_q <= '0;
        swaps_q <= '0;
      end else if (cmd_i.step) begin
        probe_q <= probe_q + 1'b1;
      end else if (cmd_i.swap) begin
        probe_q <= {1'b0, rd_q.pdist};
        swaps_q <= swaps_q + 1'b1;
      end
    end
  end

  assign out_o = out_q;

endmodule

/* verif/robin_hood_hash_table_tb.sv */
module robin_hood_hash_table_tb;
  import rht_pkg::*;

  localparam int unsigned HOME_SLOTS  = 1 << INDEX_BITS_DEF;
  localparam int unsigned TOTAL_SLOTS = HOME_SLOTS + PROBE_SLACK_DEF;
  localparam int unsigned HOME_MASK   = HOME_SLOTS - 1;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  rht_in_t          in_i;
  logic             out_valid_o;
  logic             out_ready_i;
  rht_out_t         out_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [LIM_W-1:0] cfg_data_i;

  robin_hood_hash_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow table
  logic [KEY_W-1:0] tbl_key  [TOTAL_SLOTS];
  logic [PAY_W-1:0] tbl_data [TOTAL_SLOTS];
  logic             tbl_used [TOTAL_SLOTS];
  int unsigned      tbl_dist [TOTAL_SLOTS];
  int unsigned      tbl_count;
  logic [LIM_W-1:0] cur_limit;

  rht_out_t    pending_results[$];
  logic [KEY_W-1:0] known_keys[$];
  int          err_count;
  int          sent_count;
  int          got_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;
  int          status_seen[5];

  typedef struct {
    rht_in_t  beat;
    logic     has_exp;
    status_e  exp_status;
    logic [PAY_W-1:0] exp_found;
  } dir_row_t;

  always #6 clk_i = ~clk_i;

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned eff_limit();
    return (cur_limit > PROBE_SLACK_DEF) ? PROBE_SLACK_DEF : int'(cur_limit);
  endfunction

  function automatic rht_out_t table_step(rht_in_t beat);
    rht_out_t r;
    int unsigned lim, home, probe, idx, odist;
    logic [KEY_W-1:0] ck, okey;
    logic [PAY_W-1:0] cd, odata;
    logic done;
    r = '0;
    lim = eff_limit();
    if (beat.func == FUNC_INSERT) begin
      ck = beat.key;
      cd = beat.payload;
      home = int'(ck[INDEX_BITS_DEF-1:0]);
      probe = 0;
      done = 1'b0;
      for (int g = 0; g <= TOTAL_SLOTS && !done; g++) begin
        while (probe < lim && tbl_used[home + probe] && tbl_key[home + probe] != ck &&
               tbl_dist[home + probe] >= probe)
          probe++;
        if (probe >= lim) begin
          r.status = ST_OVERFLOW;
          r.dropped_key = ck;
          r.dropped_payload = cd;
          done = 1'b1;
        end else begin
          idx = home + probe;
          if (tbl_used[idx] && tbl_key[idx] == ck) begin
            r.status = ST_DUP;
            done = 1'b1;
          end else if (!tbl_used[idx]) begin
            tbl_used[idx] = 1'b1;
            tbl_key[idx] = ck;
            tbl_data[idx] = cd;
            tbl_dist[idx] = probe;
            tbl_count++;
            r.status = ST_INSERTED;
            done = 1'b1;
          end else begin
            okey = tbl_key[idx];
            odata = tbl_data[idx];
            odist = tbl_dist[idx];
            tbl_key[idx] = ck;
            tbl_data[idx] = cd;
            tbl_dist[idx] = probe;
            ck = okey;
            cd = odata;
            probe = odist;
            home = int'(ck[INDEX_BITS_DEF-1:0]);
          end
        end
      end
      if (!done) begin
        r.status = ST_OVERFLOW;
        r.dropped_key = ck;
        r.dropped_payload = cd;
      end
    end else begin
      home = int'(beat.key[INDEX_BITS_DEF-1:0]);
      r.status = ST_MISS;
      for (int p = 0; p <= lim; p++) begin
        if (r.status == ST_MISS && tbl_used[home + p] && tbl_key[home + p] == beat.key) begin
          r.status = ST_FOUND;
          r.found_payload = tbl_data[home + p];
        end
      end
    end
    r.occupancy = tbl_count[OCC_W-1:0];
    r.over_half = tbl_count > (HOME_SLOTS >> 1);
    return r;
  endfunction

  // valid stays up after a beat is taken; it drops only for idles and drains
  task automatic offer(rht_in_t beat);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic send_beat(rht_in_t beat);
    offer(beat);
    pending_results.push_back(table_step(beat));
    if (beat.func == FUNC_INSERT) known_keys.push_back(beat.key);
  endtask

  task automatic send_row(dir_row_t row);
    rht_out_t e;
    offer(row.beat);
    e = table_step(row.beat);
    if (row.has_exp) begin
      e.status = row.exp_status;
      e.found_payload = row.exp_found;
    end
    pending_results.push_back(e);
    if (row.beat.func == FUNC_INSERT) known_keys.push_back(row.beat.key);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    while (waited < 40) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  task automatic write_limit(logic [LIM_W-1:0] lim);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= lim;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_limit = lim;
  endtask

  function automatic rht_in_t random_beat();
    rht_in_t b;
    int unsigned sel;
    b.func = 1'($urandom_range(1));
    b.payload = $urandom();
    sel = $urandom_range(9);
    if (sel < 3 && known_keys.size() != 0)
      b.key = known_keys[$urandom_range(known_keys.size() - 1)];
    else if (sel < 7)
      // crowd a few home slots near the top to force long probes
      b.key = {$urandom(), $urandom()} & ~64'(HOME_MASK) |
              64'($urandom_range(HOME_SLOTS - 1, HOME_SLOTS - 12));
    else
      b.key = {$urandom(), $urandom()};
    return b;
  endfunction

  task automatic random_phase(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) send_beat(random_beat());
  endtask

  // result side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got_count++;
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected");
          err_count++;
        end else begin
          automatic rht_out_t e = pending_results.pop_front();
          status_seen[e.status]++;
          if (out_o.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_o.status); err_count++;
          end
          if (out_o.found_payload !== e.found_payload) begin
            $error("found_payload exp %h got %h", e.found_payload, out_o.found_payload);
            err_count++;
          end
          if (out_o.dropped_key !== e.dropped_key) begin
            $error("dropped_key exp %h got %h", e.dropped_key, out_o.dropped_key); err_count++;
          end
          if (out_o.dropped_payload !== e.dropped_payload) begin
            $error("dropped_payload exp %h got %h", e.dropped_payload, out_o.dropped_payload);
            err_count++;
          end
          if (out_o.occupancy !== e.occupancy) begin
            $error("occupancy exp %0d got %0d", e.occupancy, out_o.occupancy); err_count++;
          end
          if (out_o.over_half !== e.over_half) begin
            $error("over_half exp %0d got %0d", e.over_half, out_o.over_half); err_count++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    clk_i = 0;
    rst_ni = 0;
    in_valid_i = 0;
    in_i = '0;
    out_ready_i = 0;
    cfg_valid_i = 0;
    cfg_data_i = '0;
    err_count = 0;
    sent_count = 0;
    got_count = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    for (int i = 0; i < TOTAL_SLOTS; i++) begin
      tbl_used[i] = 0; tbl_dist[i] = 0; tbl_key[i] = '0; tbl_data[i] = '0;
    end
    tbl_count = 0;
    cur_limit = LIMIT_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows; expected typed in only where obvious
    row = '{'{FUNC_LOOKUP, 64'h0, 32'h0}, 1, ST_MISS, 32'h0};                 rows.push_back(row);
    row = '{'{FUNC_INSERT, 64'h0, 32'hFFFF_FFFF}, 1, ST_INSERTED, 32'h0};     rows.push_back(row);
    row = '{'{FUNC_INSERT, 64'h0, 32'h1234}, 1, ST_DUP, 32'h0};               rows.push_back(row);
    row = '{'{FUNC_LOOKUP, 64'h0, 32'h0}, 1, ST_FOUND, 32'hFFFF_FFFF};        rows.push_back(row);
    row = '{'{FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0}, 1, ST_INSERTED, 32'h0};
    rows.push_back(row);
    row = '{'{FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF}, 1, ST_FOUND, 32'h0};
    rows.push_back(row);
    for (int i = 1; i <= 10; i++) begin
      row = '{'{FUNC_INSERT, {56'(i), 8'h10}, 32'(i * 3)}, 0, ST_INSERTED, 32'h0};
      rows.push_back(row);
    end
    row = '{'{FUNC_INSERT, 64'h55, 32'hA5A5_5A5A}, 0, ST_INSERTED, 32'h0};   rows.push_back(row);
    row = '{'{FUNC_LOOKUP, {56'd9, 8'h10}, 32'h0}, 0, ST_INSERTED, 32'h0};   rows.push_back(row);
    row = '{'{FUNC_LOOKUP, {56'd77, 8'h10}, 32'h0}, 0, ST_INSERTED, 32'h0};  rows.push_back(row);

    send_idle_pct = 10;
    recv_idle_pct = 10;
    foreach (rows[i]) send_row(rows[i]);
    drain_results();

    // limit zero: lookups check home slot only, inserts overflow
    write_limit(5'd0);
    send_beat('{FUNC_INSERT, 64'h0000_0000_0000_1110, 32'h77});
    send_beat('{FUNC_LOOKUP, {56'd1, 8'h10}, 32'h0});
    send_beat('{FUNC_LOOKUP, {56'd3, 8'h10}, 32'h0});
    drain_results();
    write_limit(5'd31);
    random_phase(350, 34, 50);
    drain_results();

    // pause until empty, then let the output stall long
    write_limit(5'd2);
    hold_cycles = 400;
    random_phase(300, 50, 34);
    drain_results();

    write_limit(5'd16);
    random_phase(200, 0, 0);
    drain_results();
    write_limit(5'd1);
    random_phase(200, 0, 0);
    drain_results();

    $display("ran %0d items, %0d results; statuses ins/dup/ovf/found/miss %0d/%0d/%0d/%0d/%0d",
             sent_count, got_count, status_seen[0], status_seen[1], status_seen[2],
             status_seen[3], status_seen[4]);
    $display("limits 0,1,2,7,16,31 exercised with long output stall and idle mixes");
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* robin_hood_hash_table.f */
sv/rht_pkg.sv
sv/rht_ctrl.sv
sv/rht_dpath.sv
sv/robin_hood_hash_table.sv
verif/robin_hood_hash_table_tb.sv
